FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ATAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("atat: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define ATAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("atat: next-cycle check failed");

`endif

FILE: rtl/core/atat_pkg.sv
package atat_pkg;

    localparam int LBA_W      = 48;
    localparam int LBA_HALF_W = 24;
    localparam int CNT_W      = 17;
    localparam int CBYTES_W   = 16;
    localparam int DEV_W      = 8;
    localparam int MODE_W     = 2;
    localparam int ADV_W      = 17;
    localparam int HEADS_W    = 5;
    localparam int SPT_W      = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    // shared divider: 48-bit dividend, divisor up to heads*spt
    localparam int DIVIDEND_W = LBA_W;
    localparam int DIVISOR_W  = HEADS_W + SPT_W;
    localparam int ITER_W     = 6;
    localparam logic [ITER_W-1:0] ITERS_BLOCK = ITER_W'(DIVIDEND_W);
    localparam logic [ITER_W-1:0] ITERS_TRACK = ITER_W'(DIVISOR_W);

    localparam logic [MODE_W-1:0] MODE_CHS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LBA28 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LBA48 = 2'd2;

    // action bit of an input word
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPT        = 1'b1;

    localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;
    localparam logic [SPT_W-1:0]   SPT_RESET   = 8'd63;

    localparam logic [CNT_W-1:0] CNT_256   = 17'h00100;
    localparam logic [CNT_W-1:0] CNT_65536 = 17'h10000;

    localparam int LBA_BIT = 6;

    typedef struct packed {
        logic                  start;
        logic [ITER_W-1:0]     iters;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic [LBA_W-1:0]    block;
        logic [CNT_W-1:0]    count;
        logic [MODE_W-1:0]   mode;
        logic [LBA_W-1:0]    lba;
        logic [CBYTES_W-1:0] cbytes;
        logic [DEV_W-1:0]    dev;
    } t_result;

endpackage

FILE: rtl/core/atat_if.sv
interface atat_in_if;
    import atat_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic                  lba48_mode;
    logic [LBA_HALF_W-1:0] lba_low_bytes;
    logic [LBA_HALF_W-1:0] lba_high_bytes;
    logic [CBYTES_W-1:0]   count_bytes;
    logic [DEV_W-1:0]      device_reg;
    logic [ADV_W-1:0]      advance_sectors;

    modport source (
        output valid, action, lba48_mode, lba_low_bytes, lba_high_bytes,
               count_bytes, device_reg, advance_sectors,
        input  ready
    );
    modport sink (
        input  valid, action, lba48_mode, lba_low_bytes, lba_high_bytes,
               count_bytes, device_reg, advance_sectors,
        output ready
    );
endinterface

interface atat_out_if;
    import atat_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LBA_W-1:0]      block_address;
    logic [CNT_W-1:0]      sector_count;
    logic [MODE_W-1:0]     address_mode;
    logic [LBA_HALF_W-1:0] out_lba_low_bytes;
    logic [LBA_HALF_W-1:0] out_lba_high_bytes;
    logic [CBYTES_W-1:0]   out_count_bytes;
    logic [DEV_W-1:0]      out_device_reg;

    modport source (
        output valid, block_address, sector_count, address_mode, out_lba_low_bytes,
               out_lba_high_bytes, out_count_bytes, out_device_reg,
        input  ready
    );
    modport sink (
        input  valid, block_address, sector_count, address_mode, out_lba_low_bytes,
               out_lba_high_bytes, out_count_bytes, out_device_reg,
        output ready
    );
endinterface

FILE: rtl/core/ata_taskfile_address_translate_core.sv
// ATA task-file address translation core.
// Input channel i_in carries one word per command event: action 0 loads a
// task file and decodes start block and sector count (CHS, LBA28, LBA48);
// action 1 advances the held address by advance_sectors, capped at the
// remaining count, and re-encodes the task-file bytes. Output channel o_out
// returns one word per input word: the held state after that event.
// Geometry (head count, sectors per track) is written through the plain
// write port i_cfg_*; the user must write it only while the core is idle,
// and the core itself does not enforce this. A CHS load with a nonzero
// sector number passes S_DMUL and S_DADD, an advance with something left
// passes S_ENC; every event ends in S_FIN. A CHS advance uses the shared
// restoring divider: 48 steps for block / (heads*spt), then 13 steps for
// the remainder / spt. i_in.ready is high only between events.
// Results sit in an output register; a new word is accepted while a result
// waits, and a finished result only stalls the core if the previous one has
// not yet been taken. Reset is synchronous: geometry returns to 16 heads and
// 63 sectors per track, all held state clears to zero (CHS mode) and the
// output register empties.
`include "assert_macros.svh"

module ata_taskfile_address_translate_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [atat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [atat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    atat_in_if.sink                            i_in,
    atat_out_if.source                         o_out
);
    import atat_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DMUL = 7'b0000010,   // CHS decode products
        S_DADD = 7'b0000100,   // CHS decode sum
        S_ENC  = 7'b0001000,   // pick re-encoding
        S_DIV1 = 7'b0010000,   // block / sectors per cylinder
        S_DIV2 = 7'b0100000,   // remainder / sectors per track
        S_FIN  = 7'b1000000    // hand result to output register
    } t_state;

    t_state r_state, n_state;

    logic [HEADS_W-1:0]   r_heads, n_heads;
    logic [SPT_W-1:0]     r_spt, n_spt;

    logic [LBA_W-1:0]     r_block, n_block;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [DEV_W-1:0]     r_dev, n_dev;
    logic [LBA_W-1:0]     r_lba, n_lba;
    logic [CBYTES_W-1:0]  r_cbytes, n_cbytes;

    // working registers
    logic [DIVISOR_W-1:0] r_spc, n_spc;
    logic [DIVISOR_W-1:0] r_off, n_off;
    logic [15:0]          r_cyl, n_cyl;

    t_result r_res, n_res;
    logic    r_out_valid, n_out_valid;

    logic [HEADS_W-1:0]   w_heads;
    logic [SPT_W-1:0]     w_spt;
    logic [28:0]          w_cyl_prod;
    logic [11:0]          w_head_prod;
    logic [ADV_W-1:0]     w_adv;
    logic [7:0]           w_c0;
    logic [MODE_W-1:0]    w_enc_mode;
    logic                 w_accept;
    logic                 w_div_phase;

    t_div_req             w_div_req;
    t_div_stat            w_div_stat;
    logic [DIVIDEND_W-1:0] w_div_quot;
    logic [DIVISOR_W-1:0]  w_div_rem;

    // zero geometry behaves as one
    assign w_heads = (r_heads == '0) ? HEADS_W'(1) : r_heads;
    assign w_spt   = (r_spt == '0) ? SPT_W'(1) : r_spt;

    assign w_cyl_prod  = {13'd0, r_lba[23:8]} * {16'd0, r_spc};
    assign w_head_prod = {8'd0, r_dev[3:0]} * {4'd0, w_spt};

    assign w_adv = (i_in.advance_sectors > r_count) ? r_count : i_in.advance_sectors;
    assign w_c0  = (r_count == CNT_256) ? 8'h00 : r_count[7:0];

    assign w_enc_mode = r_dev[LBA_BIT] ? r_mode : MODE_CHS;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_div_phase = (r_state == S_DIV1 || r_state == S_DIV2);

    // shared divider requests
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.iters    = ITERS_BLOCK;
        w_div_req.dividend = r_block;
        w_div_req.divisor  = r_spc;
        if (r_state == S_ENC && w_enc_mode == MODE_CHS) begin
            w_div_req.start = 1'b1;
        end else if (r_state == S_DIV1) begin
            w_div_req.start    = w_div_stat.done;
            w_div_req.iters    = ITERS_TRACK;
            w_div_req.dividend = {w_div_rem, (DIVIDEND_W - DIVISOR_W)'(0)};
            w_div_req.divisor  = {(DIVISOR_W - SPT_W)'(0), w_spt};
        end
    end

    atat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_heads     = r_heads;
        n_spt       = r_spt;
        n_block     = r_block;
        n_count     = r_count;
        n_mode      = r_mode;
        n_dev       = r_dev;
        n_lba       = r_lba;
        n_cbytes    = r_cbytes;
        n_spc       = r_spc;
        n_off       = r_off;
        n_cyl       = r_cyl;
        n_res       = r_res;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEAD_COUNT: n_heads = i_cfg_data[HEADS_W-1:0];
                REG_SPT:        n_spt   = i_cfg_data[SPT_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_spc = DIVISOR_W'(w_heads) * DIVISOR_W'(w_spt);
                    if (i_in.action == ACT_LOAD) begin
                        n_lba    = {i_in.lba_high_bytes, i_in.lba_low_bytes};
                        n_cbytes = i_in.count_bytes;
                        n_dev    = i_in.device_reg;
                        n_state  = S_FIN;
                        if (!i_in.device_reg[LBA_BIT]) begin
                            n_mode = MODE_CHS;
                            if (i_in.lba_low_bytes[7:0] == 8'h00) begin
                                // sector number zero: empty
                                n_block = '0;
                                n_count = '0;
                            end else begin
                                n_state = S_DMUL;
                            end
                        end else if (i_in.lba48_mode) begin
                            n_mode  = MODE_LBA48;
                            n_block = {i_in.lba_high_bytes, i_in.lba_low_bytes};
                            n_count = (i_in.count_bytes == '0) ? CNT_65536
                                                               : {1'b0, i_in.count_bytes};
                        end else begin
                            n_mode  = MODE_LBA28;
                            n_block = {20'd0, i_in.device_reg[3:0], i_in.lba_low_bytes};
                            n_count = (i_in.count_bytes[7:0] == 8'h00) ? CNT_256
                                    : {9'd0, i_in.count_bytes[7:0]};
                        end
                    end else if (r_count != '0) begin
                        n_count = r_count - w_adv;
                        n_block = r_block + {(LBA_W - ADV_W)'(0), w_adv};
                        n_state = S_ENC;
                    end else begin
                        // nothing left: state unchanged
                        n_state = S_FIN;
                    end
                end
            end
            S_DMUL: begin
                n_block = {(LBA_W - 29)'(0), w_cyl_prod};
                n_off   = {1'b0, w_head_prod} + {5'd0, r_lba[7:0]} - DIVISOR_W'(1);
                n_state = S_DADD;
            end
            S_DADD: begin
                n_block = r_block + {(LBA_W - DIVISOR_W)'(0), r_off};
                n_count = (r_cbytes[7:0] == 8'h00) ? CNT_256 : {9'd0, r_cbytes[7:0]};
                n_state = S_FIN;
            end
            S_ENC: begin
                n_mode = w_enc_mode;
                case (w_enc_mode)
                    MODE_CHS: begin
                        n_state = S_DIV1;
                    end
                    MODE_LBA28: begin
                        n_dev          = {r_dev[7:4], r_block[27:24]};
                        n_lba[23:0]    = r_block[23:0];
                        n_cbytes[7:0]  = w_c0;
                        n_state        = S_FIN;
                    end
                    MODE_LBA48: begin
                        n_lba    = r_block;
                        n_cbytes = (r_count == CNT_65536) ? 16'h0000 : r_count[15:0];
                        n_state  = S_FIN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_DIV1: begin
                if (w_div_stat.done) begin
                    // cylinder bits above 15 dropped
                    n_cyl   = w_div_quot[15:0];
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (w_div_stat.done) begin
                    n_lba[23:0]   = {r_cyl, w_div_rem[7:0] + 8'd1};
                    n_dev         = {r_dev[7:4], w_div_quot[3:0]};
                    n_cbytes[7:0] = w_c0;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_res.block  = r_block;
                    n_res.count  = r_count;
                    n_res.mode   = r_mode;
                    n_res.lba    = r_lba;
                    n_res.cbytes = r_cbytes;
                    n_res.dev    = r_dev;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heads     <= HEADS_RESET;
            r_spt       <= SPT_RESET;
            r_block     <= '0;
            r_count     <= '0;
            r_mode      <= MODE_CHS;
            r_dev       <= '0;
            r_lba       <= '0;
            r_cbytes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_heads     <= n_heads;
            r_spt       <= n_spt;
            r_block     <= n_block;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_dev       <= n_dev;
            r_lba       <= n_lba;
            r_cbytes    <= n_cbytes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spc <= n_spc;
        r_off <= n_off;
        r_cyl <= n_cyl;
        r_res <= n_res;
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.block_address      = r_res.block;
    assign o_out.sector_count       = r_res.count;
    assign o_out.address_mode       = r_res.mode;
    assign o_out.out_lba_low_bytes  = r_res.lba[LBA_HALF_W-1:0];
    assign o_out.out_lba_high_bytes = r_res.lba[LBA_W-1:LBA_HALF_W];
    assign o_out.out_count_bytes    = r_res.cbytes;
    assign o_out.out_device_reg     = r_res.dev;

    // divider only runs during the CHS re-encoding steps
    `ATAT_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, w_div_stat.busy, w_div_phase)
    // remaining count never exceeds the LBA48 maximum
    `ATAT_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, (r_count <= CNT_65536))
    // an accepted word always starts work
    `ATAT_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, w_accept, !i_in.ready)

endmodule

FILE: rtl/core/atat_div.sv
// Restoring divider, one quotient bit per cycle.
module atat_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atat_pkg::t_div_req                  i_req,
    output atat_pkg::t_div_stat                 o_stat,
    output logic [atat_pkg::DIVIDEND_W-1:0]     o_quot,
    output logic [atat_pkg::DIVISOR_W-1:0]      o_rem
);
    import atat_pkg::*;

    logic [DIVIDEND_W-1:0] r_q, n_q;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_d, n_d;
    logic [ITER_W-1:0]     r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic [DIVISOR_W:0] w_trial;
    logic [DIVISOR_W:0] w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_q[DIVIDEND_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_diff  = w_trial - {1'b0, r_d};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_d    = i_req.divisor;
            n_cnt  = i_req.iters;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = {r_q[DIVIDEND_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            n_cnt = r_cnt - ITER_W'(1);
            if (r_cnt == ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;
    assign o_rem       = r_rem;

endmodule
